### rtl/core/ncs_pkg.sv
// Shared types and constants for the nearest palette colour search block.
// No dependencies.
package ncs_pkg;

  localparam int unsigned PaletteEntriesDef = 256;
  localparam int unsigned ColourW           = 8;
  localparam int unsigned IndexW            = 8;
  localparam int unsigned IndexSpan         = 256;
  localparam int unsigned SquareW           = 16;
  localparam int unsigned DistW             = 23;

  localparam int unsigned WeightRed   = 30;
  localparam int unsigned WeightGreen = 59;
  localparam int unsigned WeightBlue  = 11;

  localparam logic CmdWrite = 1'b0;
  localparam logic CmdQuery = 1'b1;

  typedef struct packed {
    logic [ColourW-1:0] red;
    logic [ColourW-1:0] green;
    logic [ColourW-1:0] blue;
  } rgb_t;

endpackage

### rtl/core/ncs_palette_mem.sv
// Palette store: one write port, one registered read port, per-entry valid bits.
// An entry never written reads as zero. Depends on ncs_pkg.
module ncs_palette_mem #(
  parameter int unsigned Entries = ncs_pkg::PaletteEntriesDef,
  parameter int unsigned IdxW    = $clog2(Entries)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_en_i,
  input  logic [ncs_pkg::IndexW-1:0]  wr_addr_i,
  input  ncs_pkg::rgb_t               wr_data_i,
  input  logic                        rd_en_i,
  input  logic [IdxW-1:0]             rd_addr_i,
  output logic                        rd_valid_o,
  output ncs_pkg::rgb_t               rd_data_o
);

  localparam int unsigned MemDepth = (Entries < ncs_pkg::IndexSpan) ? Entries
                                                                    : ncs_pkg::IndexSpan;
  localparam int unsigned MemAw    = $clog2(MemDepth);

  ncs_pkg::rgb_t        mem_q [MemDepth];
  ncs_pkg::rgb_t        rdata_q;
  logic [MemDepth-1:0]  valid_q;
  logic                 hit_q;
  logic                 rd_valid_q;
  logic                 wr_ok;
  logic                 rd_in_range;
  logic [MemAw-1:0]     wa;
  logic [MemAw-1:0]     ra;

  assign wa          = wr_addr_i[MemAw-1:0];
  assign ra          = rd_addr_i[MemAw-1:0];
  assign wr_ok       = wr_en_i &&
                       ({1'b0, wr_addr_i} < (ncs_pkg::IndexW+1)'(MemDepth));
  assign rd_in_range = ((IdxW+1)'(rd_addr_i) < (IdxW+1)'(MemDepth));

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem_q[wa] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= mem_q[ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      hit_q      <= 1'b0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_ok) begin
        valid_q[wa] <= 1'b1;
      end
      rd_valid_q <= rd_en_i;
      if (rd_en_i) begin
        hit_q <= rd_in_range && valid_q[ra];
      end
    end
  end

  assign rd_valid_o = rd_valid_q;
  assign rd_data_o  = hit_q ? rdata_q : '0;

endmodule

### rtl/core/ncs_dist_unit.sv
// Shared two-stage weighted squared distance unit, one palette entry per cycle.
// Depends on ncs_pkg.
module ncs_dist_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  ncs_pkg::rgb_t              query_i,
  input  ncs_pkg::rgb_t              entry_i,
  output logic                       valid_o,
  output logic [ncs_pkg::DistW-1:0]  dist_o
);

  localparam int unsigned CW = ncs_pkg::ColourW;
  localparam int unsigned SW = ncs_pkg::SquareW;
  localparam int unsigned DW = ncs_pkg::DistW;

  logic [CW-1:0] dr, dg, db;
  logic [SW-1:0] sq_r_q, sq_g_q, sq_b_q;
  logic [DW-1:0] dist_d, dist_q;
  logic          v1_q, v2_q;

  assign dr = (query_i.red   > entry_i.red)   ? query_i.red   - entry_i.red
                                              : entry_i.red   - query_i.red;
  assign dg = (query_i.green > entry_i.green) ? query_i.green - entry_i.green
                                              : entry_i.green - query_i.green;
  assign db = (query_i.blue  > entry_i.blue)  ? query_i.blue  - entry_i.blue
                                              : entry_i.blue  - query_i.blue;

  assign dist_d = DW'(sq_r_q) * DW'(ncs_pkg::WeightRed)
                + DW'(sq_g_q) * DW'(ncs_pkg::WeightGreen)
                + DW'(sq_b_q) * DW'(ncs_pkg::WeightBlue);

  always_ff @(posedge clk_i) begin
    sq_r_q <= SW'(dr) * SW'(dr);
    sq_g_q <= SW'(dg) * SW'(dg);
    sq_b_q <= SW'(db) * SW'(db);
    dist_q <= dist_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  assign valid_o = v2_q;
  assign dist_o  = dist_q;

endmodule

### rtl/core/nearest_palette_color_search.sv
// Nearest palette colour search: palette writes and nearest-entry queries.
// Write transaction: ready again on the next cycle, no result.
// Query: one entry per cycle through the palette read port and the shared distance unit;
// result registered on leaving the finish state after scan and drain, input not ready meanwhile.
// Input ready again only once a query is done, later while an earlier result stalls.
// Reset: asynchronous, active low; palette reads as zero at once via valid bits.
module nearest_palette_color_search #(
  parameter int unsigned PaletteEntries = ncs_pkg::PaletteEntriesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        command_i,
  input  logic [ncs_pkg::IndexW-1:0]  entry_index_i,
  input  logic [ncs_pkg::ColourW-1:0] red_i,
  input  logic [ncs_pkg::ColourW-1:0] green_i,
  input  logic [ncs_pkg::ColourW-1:0] blue_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ncs_pkg::IndexW-1:0]  nearest_index_o
);

  localparam int unsigned IdxW = $clog2(PaletteEntries);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(PaletteEntries - 1);

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StScan   = 4'b0010,
    StDrain  = 4'b0100,
    StFinish = 4'b1000
  } state_e;

  state_e                     state_q, state_d;
  logic [IdxW-1:0]            addr_q, addr_d;
  logic [IdxW-1:0]            cmp_idx_q, cmp_idx_d;
  logic [IdxW-1:0]            best_idx_q, best_idx_d;
  logic [ncs_pkg::DistW-1:0]  best_dist_q, best_dist_d;
  logic                       first_q, first_d;
  logic                       out_valid_q, out_valid_d;
  logic [ncs_pkg::IndexW-1:0] out_idx_q, out_idx_d;
  ncs_pkg::rgb_t              query_q, query_d;
  ncs_pkg::rgb_t              in_rgb;
  logic                       accept, wr_en, start, rd_en, load_out;
  logic                       mem_valid;
  ncs_pkg::rgb_t              mem_data;
  logic                       dist_valid;
  logic [ncs_pkg::DistW-1:0]  entry_dist;

  assign in_rgb = '{red: red_i, green: green_i, blue: blue_i};
  assign accept = in_valid_i && in_ready_o;
  assign wr_en  = accept && (command_i == ncs_pkg::CmdWrite);
  assign start  = accept && (command_i == ncs_pkg::CmdQuery);

  always_comb begin
    state_d    = state_q;
    addr_d     = addr_q;
    query_d    = query_q;
    in_ready_o = 1'b0;
    rd_en      = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (start) begin
          state_d = StScan;
          addr_d  = '0;
          query_d = in_rgb;
        end
      end
      StScan: begin
        rd_en = 1'b1;
        if (addr_q == LastIdx) begin
          state_d = StDrain;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end
      StDrain: begin
        if (dist_valid && (cmp_idx_q == LastIdx)) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmp_idx_d   = cmp_idx_q;
    best_idx_d  = best_idx_q;
    best_dist_d = best_dist_q;
    first_d     = first_q;
    priority if (start) begin
      cmp_idx_d = '0;
      first_d   = 1'b1;
    end else if (dist_valid) begin
      if (first_q || (entry_dist < best_dist_q)) begin
        best_dist_d = entry_dist;
        best_idx_d  = cmp_idx_q;
      end
      cmp_idx_d = cmp_idx_q + 1'b1;
      first_d   = 1'b0;
    end
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || load_out;
  assign out_idx_d   = load_out ? ncs_pkg::IndexW'(best_idx_q) : out_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      addr_q      <= '0;
      cmp_idx_q   <= '0;
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      cmp_idx_q   <= cmp_idx_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    query_q     <= query_d;
    best_idx_q  <= best_idx_d;
    best_dist_q <= best_dist_d;
    out_idx_q   <= out_idx_d;
  end

  ncs_palette_mem #(
    .Entries (PaletteEntries),
    .IdxW    (IdxW)
  ) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_addr_i  (entry_index_i),
    .wr_data_i  (in_rgb),
    .rd_en_i    (rd_en),
    .rd_addr_i  (addr_q),
    .rd_valid_o (mem_valid),
    .rd_data_o  (mem_data)
  );

  ncs_dist_unit u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mem_valid),
    .query_i (query_q),
    .entry_i (mem_data),
    .valid_o (dist_valid),
    .dist_o  (entry_dist)
  );

  assign out_valid_o     = out_valid_q;
  assign nearest_index_o = out_idx_q;

endmodule

### rtl/core/ncs_checker.sv
// Port-level checks for nearest_palette_color_search, bound to the top level.
// Depends on ncs_pkg.
module ncs_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        command_i,
  input logic [ncs_pkg::IndexW-1:0]  entry_index_i,
  input logic [ncs_pkg::ColourW-1:0] red_i,
  input logic [ncs_pkg::ColourW-1:0] green_i,
  input logic [ncs_pkg::ColourW-1:0] blue_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [ncs_pkg::IndexW-1:0]  nearest_index_o
);

  logic in_txn;
  assign in_txn = in_valid_i && in_ready_o;

  // a query keeps the input side busy for the scan
  query_busy_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_txn && (command_i == ncs_pkg::CmdQuery) |=> !in_ready_o ##1 !in_ready_o)
    else $error("input ready during scan");

  // a write transaction never stalls the next one
  write_ready_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_txn && (command_i == ncs_pkg::CmdWrite) |=> in_ready_o)
    else $error("not ready after write");

  // a new result only follows a busy period
  result_after_scan_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without scan");

  result_hold_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(nearest_index_o))
    else $error("stalled result changed");

  input_hold_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i &&
      $stable({command_i, entry_index_i, red_i, green_i, blue_i}))
    else $error("waiting input transaction changed");

endmodule

bind nearest_palette_color_search ncs_checker u_ncs_checker (.*);

### test/testbench.sv
`timescale 1ns / 1ps
// Testbench for nearest_palette_color_search: directed and random palette writes and queries.
// Results are checked against a palette scoreboard that predicts the nearest entry per query.
// Depends on ncs_pkg and the block's RTL.
module testbench;
  import ncs_pkg::*;

  localparam int unsigned CycleLimit    = 3_000_000;
  localparam int unsigned ItemsPerPhase = 630;
  localparam int unsigned MaxReported   = 10;

  class palette_scoreboard;
    rgb_t              palette [PaletteEntriesDef];
    logic [IndexW-1:0] nearest_due [$];
    int unsigned       mismatches;

    function new();
      foreach (palette[i]) palette[i] = '0;
      mismatches = 0;
    endfunction

    function logic [DistW-1:0] weighted_dist(rgb_t a, rgb_t b);
      logic [ColourW-1:0] dr, dg, db;
      dr = (a.red > b.red) ? a.red - b.red : b.red - a.red;
      dg = (a.green > b.green) ? a.green - b.green : b.green - a.green;
      db = (a.blue > b.blue) ? a.blue - b.blue : b.blue - a.blue;
      return DistW'(WeightRed * dr * dr + WeightGreen * dg * dg + WeightBlue * db * db);
    endfunction

    // Lowest index wins on equal distance.
    function logic [IndexW-1:0] nearest_entry(rgb_t colour);
      logic [DistW-1:0] best_dist, d;
      int unsigned      best;
      best      = 0;
      best_dist = weighted_dist(colour, palette[0]);
      for (int unsigned i = 1; i < PaletteEntriesDef; i++) begin
        d = weighted_dist(colour, palette[i]);
        if (d < best_dist) begin
          best_dist = d;
          best      = i;
        end
      end
      return best[IndexW-1:0];
    endfunction

    function void note_input(logic cmd, logic [IndexW-1:0] idx, rgb_t colour);
      if (cmd == CmdWrite) begin
        if (idx < PaletteEntriesDef) palette[idx] = colour;
      end else begin
        nearest_due.push_back(nearest_entry(colour));
      end
    endfunction

    function void check_result(logic [IndexW-1:0] got);
      logic [IndexW-1:0] want;
      if (nearest_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported)
          $display("unexpected result transaction: nearest_index %0d", got);
      end else begin
        want = nearest_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MaxReported)
            $display("nearest_index mismatch: expected %0d, actual %0d", want, got);
        end
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni          = 1'b0;
  logic               in_valid_i      = 1'b0;
  logic               in_ready_o;
  logic               command_i       = CmdWrite;
  logic [IndexW-1:0]  entry_index_i   = '0;
  logic [ColourW-1:0] red_i           = '0;
  logic [ColourW-1:0] green_i         = '0;
  logic [ColourW-1:0] blue_i          = '0;
  logic               out_valid_o;
  logic               out_ready_i     = 1'b0;
  logic [IndexW-1:0]  nearest_index_o;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycle_count   = 0;

  palette_scoreboard sb = new();

  nearest_palette_color_search u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .entry_index_i   (entry_index_i),
    .red_i           (red_i),
    .green_i         (green_i),
    .blue_i          (blue_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .nearest_index_o (nearest_index_o)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(nearest_index_o);
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_item(input logic cmd, input logic [IndexW-1:0] idx, input rgb_t colour);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    entry_index_i <= idx;
    red_i         <= colour.red;
    green_i       <= colour.green;
    blue_i        <= colour.blue;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(cmd, idx, colour);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.nearest_due.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [ColourW-1:0] extreme_level();
    case ($urandom_range(5))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd127;
      3:       return 8'd128;
      4:       return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  function automatic rgb_t random_colour();
    rgb_t c;
    c.red   = ColourW'($urandom);
    c.green = ColourW'($urandom);
    c.blue  = ColourW'($urandom);
    return c;
  endfunction

  function automatic rgb_t extreme_colour();
    rgb_t c;
    c.red   = extreme_level();
    c.green = extreme_level();
    c.blue  = extreme_level();
    return c;
  endfunction

  // Small wrapping offset per channel, to land near an existing entry.
  function automatic rgb_t near_colour(rgb_t c);
    c.red   = c.red + ColourW'($urandom_range(6)) - ColourW'(3);
    c.green = c.green + ColourW'($urandom_range(6)) - ColourW'(3);
    c.blue  = c.blue + ColourW'($urandom_range(6)) - ColourW'(3);
    return c;
  endfunction

  task automatic send_random_item();
    int unsigned       roll;
    logic              cmd;
    logic [IndexW-1:0] idx;
    rgb_t              colour;
    roll = $urandom_range(99);
    idx  = IndexW'($urandom_range(IndexSpan - 1));
    if (roll < 38) begin
      cmd  = CmdQuery;
      roll = $urandom_range(99);
      if (roll < 40) colour = random_colour();
      else if (roll < 65) colour = sb.palette[$urandom_range(PaletteEntriesDef - 1)];
      else if (roll < 90) colour = near_colour(sb.palette[$urandom_range(PaletteEntriesDef - 1)]);
      else colour = extreme_colour();
    end else begin
      cmd  = CmdWrite;
      roll = $urandom_range(99);
      // copied colours make equal distances, so ties get exercised
      if (roll < 50) colour = random_colour();
      else if (roll < 75) colour = sb.palette[$urandom_range(PaletteEntriesDef - 1)];
      else colour = extreme_colour();
    end
    send_item(cmd, idx, colour);
  endtask

  task automatic run_directed();
    send_item(CmdQuery, 8'd0, {8'd0, 8'd0, 8'd0});
    send_item(CmdQuery, 8'd255, {8'd255, 8'd255, 8'd255});
    send_item(CmdWrite, 8'd255, {8'd255, 8'd255, 8'd255});
    send_item(CmdQuery, 8'd17, {8'd255, 8'd255, 8'd255});
    send_item(CmdQuery, 8'd0, {8'd200, 8'd200, 8'd200});
    send_item(CmdWrite, 8'd128, {8'd255, 8'd0, 8'd0});
    send_item(CmdWrite, 8'd64, {8'd0, 8'd255, 8'd0});
    send_item(CmdWrite, 8'd32, {8'd0, 8'd0, 8'd255});
    send_item(CmdQuery, 8'd255, {8'd255, 8'd0, 8'd0});
    send_item(CmdQuery, 8'd0, {8'd0, 8'd255, 8'd0});
    send_item(CmdQuery, 8'd0, {8'd0, 8'd0, 8'd255});
    send_item(CmdQuery, 8'd0, {8'd128, 8'd128, 8'd128});
    send_item(CmdWrite, 8'd10, {8'd100, 8'd150, 8'd200});
    send_item(CmdWrite, 8'd20, {8'd100, 8'd150, 8'd200});
    send_item(CmdQuery, 8'd0, {8'd100, 8'd150, 8'd200});
    send_item(CmdWrite, 8'd10, {8'd5, 8'd5, 8'd5});
    send_item(CmdQuery, 8'd0, {8'd100, 8'd150, 8'd200});
    send_item(CmdWrite, 8'd200, {8'd100, 8'd0, 8'd0});
    send_item(CmdQuery, 8'd0, {8'd50, 8'd0, 8'd0});
    send_item(CmdWrite, 8'd0, {8'd1, 8'd2, 8'd3});
    send_item(CmdQuery, 8'd0, {8'd0, 8'd0, 8'd0});
    send_item(CmdQuery, 8'd0, {8'd255, 8'd255, 8'd254});
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 9;
    recv_idle_pct = 73;
    run_directed();
    wait_drained();
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 9;
          recv_idle_pct = 73;
        end
        1: begin
          send_idle_pct = 73;
          recv_idle_pct = 9;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (ItemsPerPhase) send_random_item();
      wait_drained();
    end
    repeat (PaletteEntriesDef + 16) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.nearest_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (sb.nearest_due.size() != 0)
        $display("%0d query results never arrived", sb.nearest_due.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
